>>> hdl/ssrc_pkg.sv
// ----------------------------------------------------------------------------
// ssrc_pkg
// Shared constants, register indexes and the sinc magnitude table for the
// sinc sample-rate converter.
// ----------------------------------------------------------------------------
package ssrc_pkg;

  // Phase quantisation of the fractional output position.
  localparam int PHASE_STEPS = 64;
  localparam int PHASE_W     = 6;

  // Tap window limit and results allowed per input beat.
  localparam int MAX_HALF_TAPS = 8;
  localparam int RES_CAP       = 64;

  // Fixed-point constants.
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam logic [20:0]     STEP_MIN = 21'd16384;
  localparam logic signed [24:0] COEF_ONE = 25'sd8388608;

  // Divider geometry for the coefficient magnitude.
  localparam int Q_W   = 22;
  localparam int NUM_W = 29;
  localparam int DEN_W = 10;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_HALF   = 2'd1;
  localparam logic [1:0] REG_STEREO = 2'd2;

  typedef logic [Q_W-1:0] q_tab_t [PHASE_STEPS];

  // Builds round(sin(pi*f) * 2^23 / pi) for every phase, with sin taken from
  // a truncated odd Taylor series in Q30.
  function automatic q_tab_t build_q_tab();
    q_tab_t          tab;
    longint unsigned x;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned t;
    longint unsigned s;
    for (int p = 0; p < PHASE_STEPS; p++) begin
      x = (PHASE_STEPS - p < p) ? longint'(PHASE_STEPS - p) : longint'(p);
      a = (PI_Q30 * x) / PHASE_STEPS;
      a2 = (a * a) >> 30;
      t = Q30_ONE;
      t = Q30_ONE - ((a2 * t) >> 30) / 110;
      t = Q30_ONE - ((a2 * t) >> 30) / 72;
      t = Q30_ONE - ((a2 * t) >> 30) / 42;
      t = Q30_ONE - ((a2 * t) >> 30) / 20;
      t = Q30_ONE - ((a2 * t) >> 30) / 6;
      s = (a * t) >> 30;
      tab[p] = Q_W'(((s << 23) + PI_Q30 / 2) / PI_Q30);
    end
    return tab;
  endfunction

  localparam q_tab_t Q_TAB = build_q_tab();

endpackage

>>> hdl/ssrc_div.sv
// ----------------------------------------------------------------------------
// ssrc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssrc_div
  import ssrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and test it.
  assign trial = {rem_r[DEN_W-1:0], quot_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        quot_r <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r  <= fits ? trial - {1'b0, den_r} : trial;
        quot_r <= {quot_r[NUM_W-2:0], fits};
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> hdl/ssrc_hist.sv
// ----------------------------------------------------------------------------
// ssrc_hist
// Sample history memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ssrc_hist #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [47:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [47:0]              rd_data
);

  logic [47:0] mem [DEPTH];
  logic [47:0] rd_data_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/sinc_sample_rate_converter_core.sv
// ----------------------------------------------------------------------------
// sinc_sample_rate_converter_core
// Sinc interpolation resampler; one shared divider and one shared
// multiplier are sequenced tap by tap.
// ----------------------------------------------------------------------------
// Each input beat is written to the history and then yields its outputs;
// each output walks the taps in its window, skipping a tap outside the block
// or with a zero coefficient, taking the centre tap at zero phase straight to
// the multiplier and waiting on the 29-step divider for any other tap, over
// up to 17 taps. in_tready is low while a beat is worked on. Synchronous
// active-low reset clears the control state and sets step 1.0, 4 taps each
// side and mono; the history needs none.
module sinc_sample_rate_converter_core
  import ssrc_pkg::*;
#(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. in_tdata: left_sample [23:0], right_sample [47:24].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tlast,
  // Output stream. out_tdata: left_out [23:0], right_out [47:24].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int AW       = $clog2(HISTORY_DEPTH);
  localparam int HALF_LIM = (MAX_HALF_TAPS < (HISTORY_DEPTH - 1) / 2) ?
                            MAX_HALF_TAPS : (HISTORY_DEPTH - 1) / 2;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_TAP, S_DIV, S_MUL_L, S_MUL_R, S_ACC, S_OUT
  } state_t;

  state_t             state_r;
  logic [20:0]        step_r;
  logic [3:0]         half_r;
  logic               stereo_r;
  logic [31:0]        cnt_r;
  logic [39:0]        pos_r;
  logic [AW-1:0]      wp_r;
  logic [6:0]         n_r;
  logic               be_r;
  logic               final_r;
  logic signed [4:0]  k_r;
  logic signed [24:0] coef_r;
  logic signed [48:0] prod_r;
  logic signed [51:0] accl_r;
  logic signed [51:0] accr_r;
  logic               out_valid_r;
  logic [47:0]        out_data_r;
  logic               out_last_r;

  logic               in_fire;
  logic               out_load;
  logic [20:0]        step_eff;
  logic [3:0]         half_eff;
  logic [39:0]        pos_step;
  logic [23:0]        base;
  logic [32:0]        cnt33;
  logic               base_ok;
  logic               nxt_ok;
  logic               cen_ok;
  logic               more;
  logic [PHASE_W-1:0] phase;
  logic signed [34:0] m35;
  logic signed [34:0] cnt35;
  logic signed [34:0] d35;
  logic               tap_ok;
  logic signed [AW+1:0] a_raw;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic [47:0]        rd_data;
  logic signed [10:0] u;
  logic [DEN_W-1:0]   mag;
  logic [NUM_W-1:0]   div_num;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic signed [24:0] coef_div;
  logic signed [23:0] mul_a;
  logic signed [48:0] mul_p;
  logic               last_tap;

  // Saturating round of a Q46 sum back to Q1.23.
  function automatic logic [23:0] round_sat(input logic signed [51:0] acc);
    logic signed [51:0] v;
    logic signed [28:0] r;
    v = acc + 52'sd4194304;
    r = 29'(v >>> 23);
    if (r > 29'sd8388607) return 24'h7FFFFF;
    if (r < -29'sd8388608) return 24'h800000;
    return r[23:0];
  endfunction

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Register clamps.
  assign step_eff = (step_r < STEP_MIN) ? STEP_MIN : step_r;
  assign half_eff = (half_r == 4'd0) ? 4'd1 :
                    (half_r > 4'(HALF_LIM)) ? 4'(HALF_LIM) : half_r;

  // Output existence tests.
  assign pos_step = pos_r + {19'd0, step_eff};
  assign base     = pos_r[39:16];
  assign cnt33    = {1'b0, cnt_r};
  assign base_ok  = {9'd0, base} < cnt33;
  assign nxt_ok   = {9'd0, pos_step[39:16]} < cnt33;
  assign cen_ok   = ({9'd0, base} + {29'd0, half_eff}) < cnt33;
  assign more     = (n_r != 7'(RES_CAP)) && (be_r ? base_ok : (cen_ok && nxt_ok));
  assign phase    = pos_r[15:16-PHASE_W];

  // Tap position, its validity and its place in the history ring.
  assign m35    = $signed({11'd0, base}) - {{30{k_r[4]}}, k_r};
  assign cnt35  = $signed({3'd0, cnt_r});
  assign d35    = cnt35 - 35'sd1 - m35;
  assign tap_ok = !m35[34] && (m35 < cnt35) && (d35 < 35'(HISTORY_DEPTH));
  assign a_raw  = $signed({2'd0, wp_r}) - $signed({2'd0, d35[AW-1:0]}) - 2'sd1;
  assign rd_addr = a_raw[AW+1] ? AW'(a_raw + (AW+2)'(HISTORY_DEPTH)) : a_raw[AW-1:0];
  assign last_tap = (k_r == $signed({1'b0, half_eff}));

  // Coefficient divide: round(q * PHASE_STEPS / |k * PHASE_STEPS + p|).
  assign u       = $signed({k_r, phase});
  assign mag     = u[10] ? DEN_W'(-u) : u[DEN_W-1:0];
  assign div_num = {1'b0, Q_TAB[phase], 6'd0} + NUM_W'(mag[DEN_W-1:1]);
  assign coef_div = (k_r[0] ^ k_r[4]) ? -$signed({1'b0, div_quot[23:0]})
                                      : $signed({1'b0, div_quot[23:0]});

  assign rd_en     = (state_r == S_TAP) && tap_ok && !(phase == '0 && k_r != '0);
  assign div_start = rd_en && (phase != '0);

  // Shared multiplier.
  assign mul_a = (state_r == S_MUL_L) ? $signed(rd_data[23:0]) : $signed(rd_data[47:24]);
  assign mul_p = mul_a * coef_r;

  ssrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (mag),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  ssrc_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (wp_r),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 21'd65536;
      half_r      <= 4'd4;
      stereo_r    <= 1'b0;
      cnt_r       <= '0;
      pos_r       <= '0;
      wp_r        <= '0;
      n_r         <= '0;
      be_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEP:   step_r   <= cfg_data;
          REG_HALF:   half_r   <= cfg_data[3:0];
          REG_STEREO: stereo_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cnt_r   <= cnt_r + 32'd1;
            wp_r    <= (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
            be_r    <= in_tlast;
            n_r     <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (more) begin
            final_r <= be_r && ((n_r == 7'(RES_CAP - 1)) || !nxt_ok);
            accl_r  <= '0;
            accr_r  <= '0;
            k_r     <= -$signed({1'b0, half_eff});
            state_r <= S_TAP;
          end else begin
            if (be_r) begin
              cnt_r <= '0;
              pos_r <= '0;
              wp_r  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        S_TAP: begin
          if (rd_en) begin
            coef_r  <= COEF_ONE;
            state_r <= (phase == '0) ? S_MUL_L : S_DIV;
          end else if (last_tap) begin
            state_r <= S_OUT;
          end else begin
            k_r <= k_r + 5'sd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            coef_r  <= coef_div;
            state_r <= S_MUL_L;
          end
        end
        S_MUL_L: begin
          prod_r  <= mul_p;
          state_r <= S_MUL_R;
        end
        S_MUL_R: begin
          accl_r  <= accl_r + {{3{prod_r[48]}}, prod_r};
          prod_r  <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          accr_r <= accr_r + {{3{prod_r[48]}}, prod_r};
          if (last_tap) begin
            state_r <= S_OUT;
          end else begin
            k_r     <= k_r + 5'sd1;
            state_r <= S_TAP;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {stereo_r ? round_sat(accr_r) : 24'd0, round_sat(accl_r)};
            out_last_r  <= final_r;
            pos_r       <= pos_step;
            n_r         <= n_r + 7'd1;
            state_r     <= S_CHECK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A beat is worked on before the next one is taken.
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken while busy");

  // No more results per input beat than the cap.
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 7'(RES_CAP))
    else $error("result count above cap");

  // The divider only runs while the sequencer waits on it.
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider busy outside wait state");

endmodule

>>> sim/tb_sinc_sample_rate_converter_core.sv
// ----------------------------------------------------------------------------
// tb_sinc_sample_rate_converter_core
// Self-checking bench for the sinc resampler. Blocks of samples go in under
// several register settings, a behavioural resampler predicts every output
// beat, and each beat received is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_sinc_sample_rate_converter_core
  import ssrc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST = 32;
  localparam longint CYCLE_LIMIT = 64'd6000000;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic        last;
  } audio_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [20:0] cfg_data;

  sinc_sample_rate_converter_core i_dut (.*);

  // Predictor state: its own copy of the registers and sample history.
  logic [20:0]     ratio_reg;
  logic [3:0]      taps_reg;
  logic            stereo_reg;
  logic [47:0]     hist_mem [HIST];
  logic [31:0]     sample_count;
  logic [39:0]     out_pos;
  audio_beat_t     pending_beats [$];

  int     errors;
  int     beats_sent;
  int     beats_checked;
  longint cycles;
  bit     idle_enable;
  bit     hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sine in Q30 by a truncated odd series, folded about the half phase.
  function automatic longint unsigned sine_q30(int ph);
    longint unsigned x, a, a2, t;
    int divs [5];
    divs = '{110, 72, 42, 20, 6};
    x = (PHASE_STEPS - ph < ph) ? longint'(PHASE_STEPS - ph) : longint'(ph);
    a = (PI_Q30 * x) / PHASE_STEPS;
    a2 = (a * a) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - ((a2 * t) >> 30) / divs[i];
    return (a * t) >> 30;
  endfunction

  function automatic longint sinc_coef(longint k, int ph);
    longint unsigned q, c, mag;
    longint u;
    bit neg;
    if (ph == 0) return (k == 0) ? 64'sd8388608 : 0;
    q = ((sine_q30(ph) << 23) + PI_Q30 / 2) / PI_Q30;
    u = k * PHASE_STEPS + ph;
    mag = (u < 0) ? -u : u;
    if (mag == 0) return 64'sd8388608;
    c = (q * PHASE_STEPS + mag / 2) / mag;
    neg = (((k < 0) ? -k : k) % 2 != 0) != (k < 0);
    return neg ? -longint'(c) : longint'(c);
  endfunction

  function automatic logic [23:0] round_clip(longint acc);
    longint v, r;
    v = acc + (64'sd1 << 22);
    r = v >>> 23;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  // One interpolated output at position pos over the current history.
  function automatic audio_beat_t interpolate(logic [39:0] pos, longint half,
                                              longint cnt);
    audio_beat_t b;
    longint centre, m, c, accl, accr;
    int ph;
    centre = longint'(pos >> 16);
    ph = int'((pos[15:0] * 64'd64) >> 16);
    accl = 0;
    accr = 0;
    for (longint k = -half; k <= half; k++) begin
      m = centre - k;
      if (m < 0 || m >= cnt || cnt - 1 - m >= HIST) continue;
      c = sinc_coef(k, ph);
      accl += longint'($signed(hist_mem[m % HIST][23:0])) * c;
      accr += longint'($signed(hist_mem[m % HIST][47:24])) * c;
    end
    b.left = round_clip(accl);
    b.right = stereo_reg ? round_clip(accr) : 24'd0;
    b.last = 1'b0;
    return b;
  endfunction

  // Queues the outputs that one accepted input sample causes.
  task automatic predict_outputs(logic [47:0] data, logic blk_end);
    logic [39:0] step, nxt;
    longint half, cnt, cur;
    int n;
    step = (ratio_reg < STEP_MIN) ? 40'(STEP_MIN) : 40'(ratio_reg);
    half = taps_reg;
    if (half > MAX_HALF_TAPS) half = MAX_HALF_TAPS;
    if (half > (HIST - 1) / 2) half = (HIST - 1) / 2;
    if (half < 1) half = 1;
    hist_mem[sample_count % HIST] = data;
    sample_count++;
    cnt = longint'(sample_count);
    n = 0;
    if (blk_end) begin
      while (n < RES_CAP && longint'(out_pos >> 16) < cnt) begin
        pending_beats.insert(pending_beats.size(), interpolate(out_pos, half, cnt));
        out_pos = out_pos + step;
        n++;
      end
      if (n > 0) pending_beats[$].last = 1'b1;
      sample_count = 0;
      out_pos = 0;
    end else begin
      while (n < RES_CAP) begin
        cur = longint'(out_pos >> 16);
        nxt = out_pos + step;
        if (!(cur + half < cnt && longint'(nxt >> 16) < cnt)) break;
        pending_beats.insert(pending_beats.size(), interpolate(out_pos, half, cnt));
        out_pos = out_pos + step;
        n++;
      end
    end
  endtask

  // Result side: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && (!idle_enable || $urandom_range(99) >= 28);
    end
  end

  // Checks each output beat against the oldest prediction.
  always @(posedge clk) begin
    audio_beat_t exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        $error("output beat with no prediction waiting");
        errors++;
      end else begin
        exp_beat = pending_beats.pop_front();
        beats_checked++;
        if (out_tdata[23:0] !== exp_beat.left) begin
          $error("left_out expected %h actual %h", exp_beat.left, out_tdata[23:0]);
          errors++;
        end
        if (out_tdata[47:24] !== exp_beat.right) begin
          $error("right_out expected %h actual %h", exp_beat.right, out_tdata[47:24]);
          errors++;
        end
        if (out_tlast !== exp_beat.last) begin
          $error("final_out expected %b actual %b", exp_beat.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sinc_sample_rate_converter_core: mismatch");
      $finish;
    end
  end

  // The receiver holds off for a long stretch while the sender keeps offering.
  initial begin
    hold_off = 1'b0;
    wait (beats_sent == 60);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEP:   ratio_reg = val;
      REG_HALF:   taps_reg = val[3:0];
      REG_STEREO: stereo_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one sample, optionally idling first, and predicts on acceptance.
  // The valid stays up until the next sample or a drain replaces it.
  task automatic send_sample(logic [23:0] l, logic [23:0] r, logic blk_end);
    while (idle_enable && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r, l};
    in_tlast <= blk_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_outputs({r, l}, blk_end);
    beats_sent++;
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Directed rows: left, right, block end.
  logic [48:0] dir_rows [16];

  initial begin
    logic [20:0] ratios [6];
    logic [3:0]  tapset [6];
    int blk_len;
    ratios = '{21'd65536, 21'd16384, 21'd1048576, 21'd8000, 21'd40000, 21'd98304};
    tapset = '{4'd4, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    cycles = 0;
    idle_enable = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_STEP;
    cfg_data = '0;
    ratio_reg = 21'd65536;
    taps_reg = 4'd4;
    stereo_reg = 1'b0;
    sample_count = 0;
    out_pos = 0;
    for (int i = 0; i < HIST; i++) hist_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first at reset values: a lone sample block is an exact
    // copy, then extremes in mono and, at another step, in stereo.
    dir_rows = '{{24'h7FFFFF, 24'h800000, 1'b1}, {24'h800000, 24'h7FFFFF, 1'b1},
                 {24'h000000, 24'h000000, 1'b1}, {24'h7FFFFF, 24'h7FFFFF, 1'b0},
                 {24'h7FFFFF, 24'h7FFFFF, 1'b0}, {24'h800000, 24'h800000, 1'b0},
                 {24'h7FFFFF, 24'h800000, 1'b0}, {24'h123456, 24'hABCDEF, 1'b0},
                 {24'h800000, 24'h7FFFFF, 1'b0}, {24'h7FFFFF, 24'h000001, 1'b1},
                 {24'h400000, 24'hC00000, 1'b0}, {24'h7FFFFF, 24'h800000, 1'b0},
                 {24'h800000, 24'h7FFFFF, 1'b0}, {24'h7FFFFF, 24'h800000, 1'b0},
                 {24'h555555, 24'hAAAAAA, 1'b0}, {24'h800000, 24'h7FFFFF, 1'b1}};
    for (int i = 0; i < 16; i++) begin
      if (i == 10) begin
        drain_outputs();
        write_reg(REG_STEREO, 21'd1);
        write_reg(REG_STEP, 21'd24000);
      end
      send_sample(dir_rows[i][48:25], dir_rows[i][24:1], dir_rows[i][0]);
      // A one-sample block at unit step reproduces its left sample; right is zero in mono.
      if (i == 0 && pending_beats.size() == 1 && pending_beats[0] !== {24'h7FFFFF, 24'h0, 1'b1}) begin
        $error("reset copy expected %h actual %h", {24'h7FFFFF, 24'h0, 1'b1}, pending_beats[0]);
        errors++;
      end
    end

    // Random part: well-formed blocks under changing settings; under one
    // setting the blocks run past the history depth.
    idle_enable = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      drain_outputs();
      write_reg(REG_STEP, ratios[phase]);
      write_reg(REG_HALF, tapset[phase]);
      write_reg(REG_STEREO, 21'(phase % 2));
      if (phase == 5) idle_enable = 1'b0;
      while (beats_sent < 16 + 49 * (phase + 1)) begin
        blk_len = (phase == 4) ? 40 : $urandom_range(1, 12);
        // Huge steps with long blocks would be slow, keep them small.
        if (ratios[phase] > 21'd500000 && blk_len > 6) blk_len = 6;
        for (int j = 0; j < blk_len; j++)
          send_sample(rand_sample(), rand_sample(), j == blk_len - 1);
      end
      if (phase == 5) idle_enable = 1'b1;
    end
    drain_outputs();

    $display("Sent %0d input beats over six register settings, mono and stereo;",
             beats_sent);
    $display("checked %0d output beats including a long receiver hold-off.", beats_checked);
    if (errors == 0) begin
      $display("sinc_sample_rate_converter_core: match");
    end else begin
      $display("sinc_sample_rate_converter_core: mismatch");
    end
    $finish;
  end

endmodule
